[hdl/assert_macros.svh]
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`endif

[hdl/kded_pkg.sv]
package kded_pkg;

  localparam int NumDigits = 6;
  localparam int KeyW      = 8;
  localparam int SegW      = 8;
  localparam int SelW      = 7;
  localparam int CursorW   = 3;
  localparam int DigitW    = 4;

  localparam logic [KeyW-1:0] KeyLeft  = 8'h04;
  localparam logic [KeyW-1:0] KeyRight = 8'h08;
  localparam logic [KeyW-1:0] KeyUp    = 8'h10;
  localparam logic [KeyW-1:0] KeyDown  = 8'h20;
  localparam logic [KeyW-1:0] KeyEsc   = 8'h40;
  localparam logic [KeyW-1:0] KeyEnter = 8'h80;

  localparam logic [SegW-1:0]   LedPattern = 8'h10;
  localparam logic [DigitW-1:0] DigitMax   = 4'd9;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] keys;
  } kded_item_t;

  // gfedcba code; values above nine are blank
  function automatic logic [SegW-1:0] seg_encode(input logic [DigitW-1:0] value);
    logic [SegW-1:0] code;
    unique case (value)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

[hdl/kded_in_stage.sv]
module kded_in_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kded_pkg::KeyW-1:0]     keys_i,
  input  logic                          take_i,
  output kded_pkg::kded_item_t          item_o
);

  logic                      valid_q, valid_d;
  logic [kded_pkg::KeyW-1:0] keys_q, keys_d;
  logic                      accept;

  assign in_ready_o = !valid_q || take_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    keys_d  = keys_q;
    if (accept) begin
      valid_d = 1'b1;
      keys_d  = keys_i;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q <= keys_d;
  end

  assign item_o = '{valid: valid_q, keys: keys_q};

endmodule

[hdl/kded_core.sv]
module kded_core #(
  parameter int NUM_DIGITS = kded_pkg::NumDigits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  kded_pkg::kded_item_t          item_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kded_pkg::SelW-1:0]     digit_select_o,
  output logic [kded_pkg::SegW-1:0]     segments_o,
  output logic                          led_level_o
);

  localparam int ScanW   = NUM_DIGITS + 1;
  localparam int CursorW = kded_pkg::CursorW;
  localparam int DigitW  = kded_pkg::DigitW;
  localparam int SelW    = kded_pkg::SelW;
  localparam logic [CursorW-1:0] CursorMax = CursorW'(NUM_DIGITS - 1);
  localparam logic [CursorW-1:0] CursorRst =
    CursorW'((NUM_DIGITS - 1 < 3) ? NUM_DIGITS - 1 : 3);
  localparam logic [ScanW-1:0] ScanFirst = ScanW'(1);

  logic [kded_pkg::KeyW-1:0] last_keys_q, last_keys_d;
  logic [ScanW-1:0]          scan_q, scan_d, scan_base;
  logic [CursorW-1:0]        cursor_q, cursor_d, cur;
  logic [DigitW-1:0]         digit_q [NUM_DIGITS];
  logic [DigitW-1:0]         digit_d [NUM_DIGITS];
  logic                      led_q, led_d;
  logic [kded_pkg::KeyW-1:0] fresh;

  logic                      out_valid_q, out_valid_d;
  logic [SelW-1:0]           dsel_q, dsel_d;
  logic [kded_pkg::SegW-1:0] seg_q, seg_d;
  logic                      led_out_q;
  logic [SelW+ScanW-1:0]     sel_ext;

  assign take_o = item_i.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    fresh       = item_i.keys & ~last_keys_q;
    cur         = (cursor_q > CursorMax) ? CursorMax : cursor_q;
    cursor_d    = cursor_q;
    digit_d     = digit_q;
    led_d       = led_q;
    scan_base   = scan_q;
    last_keys_d = item_i.keys;
    unique case (fresh)
      kded_pkg::KeyLeft: begin
        cursor_d = (cur < CursorMax) ? cur + CursorW'(1) : cur;
      end
      kded_pkg::KeyRight: begin
        cursor_d = (cur != '0) ? cur - CursorW'(1) : cur;
      end
      kded_pkg::KeyUp: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (cur == CursorW'(i)) begin
            digit_d[i] = (digit_q[i] < kded_pkg::DigitMax) ?
                         digit_q[i] + DigitW'(1) : kded_pkg::DigitMax;
          end
        end
      end
      kded_pkg::KeyDown: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          if (cur == CursorW'(i) && digit_q[i] != '0) begin
            digit_d[i] = digit_q[i] - DigitW'(1);
          end
        end
      end
      kded_pkg::KeyEsc: begin
        for (int i = 0; i < NUM_DIGITS; i++) begin
          digit_d[i] = DigitW'(i);
        end
        cursor_d  = CursorRst;
        scan_base = ScanFirst;
      end
      kded_pkg::KeyEnter: begin
        led_d = !led_q;
      end
      default: begin
      end
    endcase
    // rotate over digit positions plus the LED position
    scan_d = scan_base[NUM_DIGITS] ? ScanFirst : (scan_base << 1);
  end

  always_comb begin
    seg_d = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (scan_d[i]) begin
        seg_d = seg_d | kded_pkg::seg_encode(digit_d[i]);
      end
    end
    if (scan_d[NUM_DIGITS]) begin
      seg_d = kded_pkg::LedPattern;
    end
    sel_ext     = {{SelW{1'b0}}, scan_d};
    dsel_d      = sel_ext[SelW-1:0];
    out_valid_d = take_o || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_keys_q <= '0;
      scan_q      <= ScanFirst;
      cursor_q    <= CursorRst;
      led_q       <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_q[i] <= DigitW'(i);
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        last_keys_q <= last_keys_d;
        scan_q      <= scan_d;
        cursor_q    <= cursor_d;
        led_q       <= led_d;
        digit_q     <= digit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      dsel_q    <= dsel_d;
      seg_q     <= seg_d;
      led_out_q <= led_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign digit_select_o = dsel_q;
  assign segments_o     = seg_q;
  assign led_level_o    = led_out_q;

endmodule

[hdl/keypad_digit_editor_display_scan_unit.sv]
// Keypad digit editor with a multiplexed seven-segment scan. Each item is one
// poll of the key register; keys newly pressed since the previous poll are
// decoded, and a single new key moves the cursor, edits the digit under it,
// restores the display or toggles the LED pin. Every poll then steps the
// one-hot scan and yields one result: the select, its segment code and the LED
// level. One item is taken per clock cycle while the output is not stalled; an
// accepted item waits in the input register until the state update takes it
// and writes the result register. Output stalls back up through both
// registers.
`include "assert_macros.svh"

module keypad_digit_editor_display_scan_unit #(
  parameter int NUM_DIGITS = kded_pkg::NumDigits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [kded_pkg::KeyW-1:0]     keys_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [kded_pkg::SelW-1:0]     digit_select_o,
  output logic [kded_pkg::SegW-1:0]     segments_o,
  output logic                          led_level_o
);

  localparam logic [kded_pkg::SelW-1:0] LedSel = kded_pkg::SelW'(1 << NUM_DIGITS);

  kded_pkg::kded_item_t item;
  logic                 take;
  logic                 at_led;
  logic                 led_seg;

  kded_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .keys_i     (keys_i),
    .take_i     (take),
    .item_o     (item)
  );

  kded_core #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digit_select_o (digit_select_o),
    .segments_o     (segments_o),
    .led_level_o    (led_level_o)
  );

  assign at_led  = (digit_select_o == LedSel);
  assign led_seg = (segments_o == kded_pkg::LedPattern);

  `ASSERT_PROP(a_sel_onehot, clk_i, rst_ni, out_valid_o |-> $onehot0(digit_select_o))
  `ASSERT_PROP(a_led_pattern, clk_i, rst_ni, (out_valid_o && at_led) |-> led_seg)
  `ASSERT_PROP(a_digit_code, clk_i, rst_ni, (out_valid_o && !at_led) |-> !led_seg)
  `ASSERT_NEVER(a_stall_source, clk_i, rst_ni, !in_ready_o && !(out_valid_o && !out_ready_i))

endmodule

[tb/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchdogLimit = 3000;
  localparam int LongHoldCycles = 60;
  localparam logic [7:0] LedPos = 8'(1 << kded_pkg::NumDigits);
  localparam logic [kded_pkg::SegW-1:0] DigitCodes [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  typedef struct packed {
    logic [kded_pkg::SelW-1:0] sel;
    logic [kded_pkg::SegW-1:0] seg;
    logic                      led;
  } scan_frame_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  logic [kded_pkg::KeyW-1:0] keys_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [kded_pkg::SelW-1:0] digit_select_o;
  logic [kded_pkg::SegW-1:0] segments_o;
  logic                      led_level_o;

  keypad_digit_editor_display_scan_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .keys_i         (keys_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digit_select_o (digit_select_o),
    .segments_o     (segments_o),
    .led_level_o    (led_level_o)
  );

  always #10 clk_i = ~clk_i;

  // display model state
  logic [kded_pkg::KeyW-1:0]    prev_keys;
  logic [7:0]                   scan_pos;
  logic [kded_pkg::CursorW-1:0] cursor_pos;
  logic [kded_pkg::DigitW-1:0]  digit_val [kded_pkg::NumDigits];
  logic                         led_lvl;

  scan_frame_t frames_due [$];
  int          errors = 0;
  int          idle_cycles = 0;

  // stimulus control
  logic [kded_pkg::KeyW-1:0] sent_keys = '0;
  int                        burst_left = 0;
  bit                        no_gaps = 1'b0;
  bit                        long_hold_req = 1'b0;

  function automatic void step_scan();
    scan_pos = scan_pos << 1;
    if (scan_pos > LedPos || scan_pos == 8'd0) scan_pos = 8'd1;
  endfunction

  function automatic void restore_display();
    for (int i = 0; i < kded_pkg::NumDigits; i++) digit_val[i] = kded_pkg::DigitW'(i);
    cursor_pos = kded_pkg::CursorW'((3 < kded_pkg::NumDigits - 1) ?
                                    3 : kded_pkg::NumDigits - 1);
    scan_pos = LedPos;
    step_scan();
  endfunction

  function automatic scan_frame_t poll_display(input logic [kded_pkg::KeyW-1:0] k);
    logic [kded_pkg::KeyW-1:0] fresh;
    scan_frame_t               f;
    fresh = (prev_keys ^ k) & k;
    case (fresh)
      kded_pkg::KeyLeft:  if (cursor_pos < kded_pkg::NumDigits - 1) cursor_pos++;
      kded_pkg::KeyRight: if (cursor_pos > 0) cursor_pos--;
      kded_pkg::KeyUp:
        if (digit_val[cursor_pos] < kded_pkg::DigitMax) digit_val[cursor_pos]++;
      kded_pkg::KeyDown:  if (digit_val[cursor_pos] > 0) digit_val[cursor_pos]--;
      kded_pkg::KeyEsc:   restore_display();
      kded_pkg::KeyEnter: led_lvl = ~led_lvl;
      default: ;
    endcase
    prev_keys = k;
    step_scan();
    f.sel = scan_pos[kded_pkg::SelW-1:0];
    f.seg = '0;
    if (scan_pos == LedPos) begin
      f.seg = kded_pkg::LedPattern;
    end else begin
      for (int i = 0; i < kded_pkg::NumDigits; i++) begin
        if (scan_pos == 8'(1 << i) && digit_val[i] <= kded_pkg::DigitMax) begin
          f.seg = DigitCodes[digit_val[i]];
        end
      end
    end
    f.led = led_lvl;
    return f;
  endfunction

  // predicts on each accepted poll, checks each accepted result, watchdog
  always @(posedge clk_i) begin
    scan_frame_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) frames_due.push_back(poll_display(keys_i));
      if (out_valid_o && out_ready_i) begin
        if (frames_due.size() == 0) begin
          $error("result with no item pending: sel %0h seg %0h led %0b",
                 digit_select_o, segments_o, led_level_o);
          errors++;
        end else begin
          want = frames_due.pop_front();
          if (digit_select_o !== want.sel) begin
            $error("digit_select: expected %0h, got %0h", want.sel, digit_select_o);
            errors++;
          end
          if (segments_o !== want.seg) begin
            $error("segments: expected %0h, got %0h", want.seg, segments_o);
            errors++;
          end
          if (led_level_o !== want.led) begin
            $error("led_level: expected %0b, got %0b", want.led, led_level_o);
            errors++;
          end
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // receiver stall pattern
  int rx_cycle = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    rx_cycle++;
    if (long_hold_req) begin
      hold_left = LongHoldCycles;
      long_hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case ((rx_cycle / 80) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= (rx_cycle % 4 == 0);
        default: out_ready_i <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_keys(input logic [kded_pkg::KeyW-1:0] k);
    int gap;
    in_valid_i <= 1'b1;
    keys_i <= k;
    sent_keys = k;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic press_key(input logic [kded_pkg::KeyW-1:0] k);
    send_keys(k);
    send_keys('0);
  endtask

  function automatic logic [kded_pkg::KeyW-1:0] pick_command();
    int r;
    r = $urandom_range(0, 99);
    if (r < 19) return kded_pkg::KeyLeft;
    if (r < 38) return kded_pkg::KeyRight;
    if (r < 57) return kded_pkg::KeyUp;
    if (r < 76) return kded_pkg::KeyDown;
    if (r < 95) return kded_pkg::KeyEnter;
    return kded_pkg::KeyEsc;
  endfunction

  task automatic test_cursor_limits();
    press_key(kded_pkg::KeyLeft);
    press_key(kded_pkg::KeyLeft);
    send_keys(kded_pkg::KeyLeft);  // saturates at top
  endtask

  task automatic test_digit_limits();
    repeat (4) press_key(kded_pkg::KeyUp);
    send_keys(kded_pkg::KeyUp);  // nine stays nine
    send_keys('0);
    send_keys(kded_pkg::KeyEsc);
    send_keys('0);
    repeat (3) press_key(kded_pkg::KeyRight);
    press_key(kded_pkg::KeyDown);  // zero stays zero
    send_keys(kded_pkg::KeyRight); // cursor stays at zero
  endtask

  task automatic test_key_collisions();
    send_keys(kded_pkg::KeyEnter);
    send_keys(kded_pkg::KeyEnter | kded_pkg::KeyLeft);  // held enter, fresh left
    send_keys(kded_pkg::KeyLeft | kded_pkg::KeyUp);     // held left, fresh up
    send_keys(8'h01 | kded_pkg::KeyDown);
    send_keys(8'hFF);
    send_keys('0);
    send_keys(8'h02);
    send_keys(8'h02 | kded_pkg::KeyEnter);
  endtask

  task automatic test_random_polls();
    int n;
    logic [kded_pkg::KeyW-1:0] cmd;
    int r;
    n = 0;
    while (n < 400) begin
      no_gaps = (n >= 150 && n < 230);
      r = $urandom_range(0, 99);
      cmd = pick_command();
      if (r < 60) begin
        send_keys(cmd);
        n++;
        if ($urandom_range(0, 1) != 0) begin
          send_keys('0);
          n++;
        end
      end else if (r < 80) begin
        send_keys(sent_keys | cmd);
        n++;
      end else begin
        send_keys(kded_pkg::KeyW'($urandom_range(0, 255)));
        n++;
      end
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_backpressure();
    no_gaps = 1'b1;
    long_hold_req = 1'b1;
    repeat (30) send_keys(pick_command() | (sent_keys & 8'h03));
    no_gaps = 1'b0;
  endtask

  initial begin
    prev_keys = '0;
    led_lvl = 1'b1;
    restore_display();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_cursor_limits();
    test_digit_limits();
    test_key_collisions();
    test_random_polls();
    test_backpressure();

    in_valid_i <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
